// ===== rtl/core/sdf_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sdf_pkg: shared definitions for the signed decimal field formatter
// Widths, character codes, flag bit positions and the cell control bundle.
// ----------------------------------------------------------------------------
package sdf_pkg;

   // value and digit geometry
   localparam int VALUE_WIDTH       = 32;
   localparam int NUM_DIGITS        = 10;
   localparam int DIGIT_WIDTH       = 4;
   localparam int FLAGS_WIDTH       = 4;
   localparam int PAD_WIDTH_BITS    = 6;
   localparam int CHAR_WIDTH        = 8;
   localparam int MAX_WIDTH_DEFAULT = 63;

   // flag bit positions
   localparam int FLAG_LEFT  = 0;
   localparam int FLAG_PLUS  = 1;
   localparam int FLAG_SPACE = 2;
   localparam int FLAG_ZERO  = 3;

   // ascii codes
   localparam logic [CHAR_WIDTH-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [CHAR_WIDTH-1:0] CHAR_PLUS  = 8'h2B;
   localparam logic [CHAR_WIDTH-1:0] CHAR_MINUS = 8'h2D;
   localparam logic [CHAR_WIDTH-1:0] CHAR_SPACE = 8'h20;

   // per-cycle command to every digit cell
   typedef struct packed {
      logic clear;   // load zero
      logic dabble;  // add-3 adjust and shift one bit in
      logic shift;   // take the lower neighbor's digit
   } cell_ctrl_type;

endpackage
`default_nettype wire

// ===== rtl/core/sdf_digit_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sdf_digit_cell: one bcd digit of the conversion chain
// Holds one decimal digit; shifts binary bits in with add-3 correction and
// later passes whole digits up the chain toward the output.
// ----------------------------------------------------------------------------
module sdf_digit_cell (
   input  wire                                  clock,
   input  wire  sdf_pkg::cell_ctrl_type         ctrl,
   input  wire                                  bit_in,
   input  wire  [sdf_pkg::DIGIT_WIDTH-1:0]      digit_in,
   output logic                                 bit_out,
   output logic [sdf_pkg::DIGIT_WIDTH-1:0]      digit
);

   logic [sdf_pkg::DIGIT_WIDTH-1:0] digit_ff;
   logic [sdf_pkg::DIGIT_WIDTH-1:0] digit_in_next;
   logic [sdf_pkg::DIGIT_WIDTH-1:0] adj;

   // add-3 correction before the shift
   always_comb begin
      adj = (digit_ff >= 4'd5) ? (digit_ff + 4'd3) : digit_ff;
   end

   assign bit_out = adj[sdf_pkg::DIGIT_WIDTH-1];
   assign digit   = digit_ff;

   // next digit selection
   always_comb begin
      digit_in_next = digit_ff;
      if (ctrl.clear) begin
         digit_in_next = '0;
      end else if (ctrl.dabble) begin
         digit_in_next = {adj[sdf_pkg::DIGIT_WIDTH-2:0], bit_in};
      end else if (ctrl.shift) begin
         digit_in_next = digit_in;
      end
   end

   always_ff @(posedge clock) begin
      digit_ff <= digit_in_next;
   end

endmodule
`default_nettype wire

// ===== rtl/core/signed_decimal_field_formatter.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// signed_decimal_field_formatter: printf %d conversion, one character a cycle while emitting
// Converts a signed 32-bit value to its padded decimal field through a chain
// of bcd digit cells and streams the ascii characters with a last mark.
// ----------------------------------------------------------------------------
// Pulse start while busy is low to hand over one transaction (value, flags,
// pad_width). Characters come out on rsp_ch with rsp_valid high for exactly
// one cycle each, most significant first, rsp_last on the final one; the
// receiver must take every character as it appears. A transaction keeps busy
// high through the bit-serial binary to bcd conversion in the ten-cell chain,
// the sizing state, the leading-zero drop and the emission of the field
// (as long as the larger of width and text length), one character a cycle.
// busy stays high until the last character has been registered, so the next
// transaction can be taken in the cycle that shows the last character.
module signed_decimal_field_formatter #(
   parameter int MAX_WIDTH = sdf_pkg::MAX_WIDTH_DEFAULT
) (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   start,
   output logic                                  busy,
   input  wire  [sdf_pkg::VALUE_WIDTH-1:0]       req_value,
   input  wire  [sdf_pkg::FLAGS_WIDTH-1:0]       req_flags,
   input  wire  [sdf_pkg::PAD_WIDTH_BITS-1:0]    req_pad_width,
   output logic                                  rsp_valid,
   output logic [sdf_pkg::CHAR_WIDTH-1:0]        rsp_ch,
   output logic                                  rsp_last
);

   localparam int ND = sdf_pkg::NUM_DIGITS;
   localparam int DW = sdf_pkg::DIGIT_WIDTH;
   localparam int VW = sdf_pkg::VALUE_WIDTH;
   localparam int PW = sdf_pkg::PAD_WIDTH_BITS;
   localparam int BCW = $clog2(VW);
   localparam int NDW = $clog2(ND + 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CONV,
      ST_SIZE,
      ST_SKIP,
      ST_EMIT
   } state_type;

   state_type                     state_ff;
   logic [VW-1:0]                 mag_ff;
   logic [BCW-1:0]                bit_cnt_ff;
   logic [sdf_pkg::FLAGS_WIDTH-1:0] flags_ff;
   logic [PW-1:0]                 width_ff;
   logic                          has_sign_ff;
   logic [sdf_pkg::CHAR_WIDTH-1:0] sign_ch_ff;
   logic [NDW-1:0]                dig_cnt_ff;
   logic [NDW-1:0]                skip_cnt_ff;
   logic [PW-1:0]                 pad_cnt_ff;
   logic [PW-1:0]                 rem_ff;
   logic                          rsp_valid_ff;
   logic [sdf_pkg::CHAR_WIDTH-1:0] rsp_ch_ff;
   logic                          rsp_last_ff;

   sdf_pkg::cell_ctrl_type        cell_ctrl;
   logic [ND-1:0]                 cell_bit;
   logic [DW-1:0]                 cell_digit [ND];

   logic                          accept;
   logic [PW-1:0]                 width_sat;
   logic [NDW-1:0]                nd_calc;
   logic [PW-1:0]                 len_calc;
   logic [PW-1:0]                 pad_calc;
   logic                          left_al;
   logic                          zero_al;
   logic [sdf_pkg::CHAR_WIDTH-1:0] top_ch;

   assign accept    = start && (state_ff == ST_IDLE);
   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_ch    = rsp_ch_ff;
   assign rsp_last  = rsp_last_ff;
   assign left_al   = flags_ff[sdf_pkg::FLAG_LEFT];
   assign zero_al   = flags_ff[sdf_pkg::FLAG_ZERO];
   assign top_ch    = sdf_pkg::CHAR_ZERO + {{(sdf_pkg::CHAR_WIDTH - DW){1'b0}},
                                           cell_digit[ND-1]};

   // width saturation
   always_comb begin
      if (int'(req_pad_width) > MAX_WIDTH) begin
         width_sat = PW'(MAX_WIDTH);
      end else begin
         width_sat = req_pad_width;
      end
   end

   // cell commands
   always_comb begin
      cell_ctrl.clear  = accept;
      cell_ctrl.dabble = (state_ff == ST_CONV);
      cell_ctrl.shift  = (state_ff == ST_SKIP) ||
                         ((state_ff == ST_EMIT) && !(!left_al && !zero_al &&
                          (pad_cnt_ff != '0)) && !has_sign_ff &&
                          !(!left_al && zero_al && (pad_cnt_ff != '0)) &&
                          (dig_cnt_ff != '0));
   end

   // digit chain
   for (genvar k = 0; k < ND; k++) begin : g_cell
      logic          bit_src;
      logic [DW-1:0] digit_src;
      if (k == 0) begin : g_first
         assign bit_src   = mag_ff[VW-1];
         assign digit_src = '0;
      end else begin : g_rest
         assign bit_src   = cell_bit[k-1];
         assign digit_src = cell_digit[k-1];
      end
      sdf_digit_cell u_cell (
         .clock    (clock),
         .ctrl     (cell_ctrl),
         .bit_in   (bit_src),
         .digit_in (digit_src),
         .bit_out  (cell_bit[k]),
         .digit    (cell_digit[k])
      );
   end

   // digit count from the highest nonzero cell
   always_comb begin
      nd_calc = NDW'(1);
      for (int k = 1; k < ND; k++) begin
         if (cell_digit[k] != '0) begin
            nd_calc = NDW'(k + 1);
         end
      end
      len_calc = PW'(nd_calc) + PW'(has_sign_ff);
      pad_calc = (width_ff > len_calc) ? (width_ff - len_calc) : '0;
   end

   // control and output registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         rsp_last_ff  <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         rsp_last_ff  <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  mag_ff      <= req_value[VW-1] ? (VW'(0) - req_value) : req_value;
                  flags_ff    <= req_flags;
                  width_ff    <= width_sat;
                  bit_cnt_ff  <= '0;
                  has_sign_ff <= req_value[VW-1] ||
                                 ((req_value != '0) &&
                                  (req_flags[sdf_pkg::FLAG_PLUS] ||
                                   req_flags[sdf_pkg::FLAG_SPACE]));
                  if (req_value[VW-1]) begin
                     sign_ch_ff <= sdf_pkg::CHAR_MINUS;
                  end else if (req_flags[sdf_pkg::FLAG_PLUS]) begin
                     sign_ch_ff <= sdf_pkg::CHAR_PLUS;
                  end else begin
                     sign_ch_ff <= sdf_pkg::CHAR_SPACE;
                  end
                  state_ff    <= ST_CONV;
               end
            end
            ST_CONV: begin
               mag_ff     <= {mag_ff[VW-2:0], 1'b0};
               bit_cnt_ff <= bit_cnt_ff + 1'b1;
               if (bit_cnt_ff == BCW'(VW - 1)) begin
                  state_ff <= ST_SIZE;
               end
            end
            ST_SIZE: begin
               dig_cnt_ff  <= nd_calc;
               skip_cnt_ff <= NDW'(ND) - nd_calc;
               pad_cnt_ff  <= pad_calc;
               rem_ff      <= len_calc + pad_calc;
               state_ff    <= (nd_calc == NDW'(ND)) ? ST_EMIT : ST_SKIP;
            end
            ST_SKIP: begin
               skip_cnt_ff <= skip_cnt_ff - 1'b1;
               if (skip_cnt_ff == NDW'(1)) begin
                  state_ff <= ST_EMIT;
               end
            end
            ST_EMIT: begin
               rsp_valid_ff <= 1'b1;
               rsp_last_ff  <= (rem_ff == PW'(1));
               rem_ff       <= rem_ff - 1'b1;
               if (rem_ff == PW'(1)) begin
                  state_ff <= ST_IDLE;
               end
               // leading spaces, sign, zeros, digits, trailing spaces
               if (!left_al && !zero_al && (pad_cnt_ff != '0)) begin
                  rsp_ch_ff  <= sdf_pkg::CHAR_SPACE;
                  pad_cnt_ff <= pad_cnt_ff - 1'b1;
               end else if (has_sign_ff) begin
                  rsp_ch_ff   <= sign_ch_ff;
                  has_sign_ff <= 1'b0;
               end else if (!left_al && zero_al && (pad_cnt_ff != '0)) begin
                  rsp_ch_ff  <= sdf_pkg::CHAR_ZERO;
                  pad_cnt_ff <= pad_cnt_ff - 1'b1;
               end else if (dig_cnt_ff != '0) begin
                  rsp_ch_ff  <= top_ch;
                  dig_cnt_ff <= dig_cnt_ff - 1'b1;
               end else begin
                  rsp_ch_ff  <= sdf_pkg::CHAR_SPACE;
                  pad_cnt_ff <= pad_cnt_ff - 1'b1;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   // accepted transaction makes the block busy
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after accepted transaction");

   // a character other than the last one comes while the field is in progress
   a_mid_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last) |-> busy)
      else $error("field ended without a last mark");

   // the last character frees the block
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last) |-> !busy)
      else $error("block still busy after last character");

   // no character directly after a last mark
   a_last_gap: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last) |=> !rsp_valid)
      else $error("character emitted right after last mark");

endmodule
`default_nettype wire

// ===== sim/tb_signed_decimal_field_formatter.sv =====
// ----------------------------------------------------------------------------
// tb_signed_decimal_field_formatter: self-checking bench for the %d formatter
// A queue-fed driver hands values, flags and widths to the block. An in-bench
// model of the printf %d field builds the expected character stream, and a
// monitor checks every character and its last mark in order.
// ----------------------------------------------------------------------------
module tb_signed_decimal_field_formatter;

   localparam int VW          = sdf_pkg::VALUE_WIDTH;
   localparam int FW          = sdf_pkg::FLAGS_WIDTH;
   localparam int PWB         = sdf_pkg::PAD_WIDTH_BITS;
   localparam int CW          = sdf_pkg::CHAR_WIDTH;
   localparam int MAX_FIELD   = sdf_pkg::MAX_WIDTH_DEFAULT;
   localparam int STALL_LIMIT = 2000;
   localparam int DRAIN_CYCLES = 200;

   // one formatting request plus the sender idle rate used while it waits
   typedef struct {
      logic [VW-1:0]  value;
      logic [FW-1:0]  flags;
      logic [PWB-1:0] pad_w;
      int             idle_pct;
   } fmt_req_type;

   // one expected output character
   typedef struct {
      logic [CW-1:0] ch;
      logic          last;
   } field_char_type;

   logic                      clock;
   logic                      reset;
   logic                      start;
   logic                      busy;
   logic [VW-1:0]             req_value;
   logic [FW-1:0]             req_flags;
   logic [PWB-1:0]            req_pad_width;
   logic                      rsp_valid;
   logic [CW-1:0]             rsp_ch;
   logic                      rsp_last;

   fmt_req_type    fmt_req_q[$];
   field_char_type field_chars_q[$];
   int             error_count;
   int             stall_count;

   signed_decimal_field_formatter dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_value     (req_value),
      .req_flags     (req_flags),
      .req_pad_width (req_pad_width),
      .rsp_valid     (rsp_valid),
      .rsp_ch        (rsp_ch),
      .rsp_last      (rsp_last)
   );

   // clock, reset and known input levels
   initial begin
      clock         = 1'b0;
      reset         = 1'b1;
      start         = 1'b0;
      req_value     = '0;
      req_flags     = '0;
      req_pad_width = '0;
      forever #5 clock = ~clock;
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("ERROR %0t: %s got 0x%0h expected 0x%0h", $realtime, what, got, want);
      error_count++;
   endtask

   // expected character stream of one %d field
   function automatic void format_field(input logic [VW-1:0] value,
                                        input logic [FW-1:0] flags,
                                        input logic [PWB-1:0] pad_w);
      logic [CW-1:0]  digits [sdf_pkg::NUM_DIGITS];
      logic [CW-1:0]  text [$];
      logic [VW-1:0]  mag;
      logic [CW-1:0]  sign_ch;
      bit             has_sign;
      int             nd;
      int             field_w;
      int             text_len;
      int             pad;
      field_char_type fc;
      mag = value[VW-1] ? (32'd0 - value) : value;
      nd  = 0;
      // digits least significant first
      do begin
         digits[nd] = sdf_pkg::CHAR_ZERO + CW'(mag % 10);
         nd++;
         mag = mag / 10;
      end while (mag != 0 && nd < sdf_pkg::NUM_DIGITS);
      // sign: minus, else plus, else space; zero never signed
      has_sign = 1'b1;
      sign_ch  = sdf_pkg::CHAR_SPACE;
      if (value[VW-1])
         sign_ch = sdf_pkg::CHAR_MINUS;
      else if (value != 0 && flags[sdf_pkg::FLAG_PLUS])
         sign_ch = sdf_pkg::CHAR_PLUS;
      else if (value != 0 && flags[sdf_pkg::FLAG_SPACE])
         sign_ch = sdf_pkg::CHAR_SPACE;
      else
         has_sign = 1'b0;
      field_w = (pad_w > MAX_FIELD) ? MAX_FIELD : int'(pad_w);
      text_len = nd + int'(has_sign);
      pad = (field_w > text_len) ? field_w - text_len : 0;
      if (flags[sdf_pkg::FLAG_LEFT]) begin
         if (has_sign) text.push_back(sign_ch);
         for (int i = nd - 1; i >= 0; i--) text.push_back(digits[i]);
         repeat (pad) text.push_back(sdf_pkg::CHAR_SPACE);
      end else if (flags[sdf_pkg::FLAG_ZERO]) begin
         if (has_sign) text.push_back(sign_ch);
         repeat (pad) text.push_back(sdf_pkg::CHAR_ZERO);
         for (int i = nd - 1; i >= 0; i--) text.push_back(digits[i]);
      end else begin
         repeat (pad) text.push_back(sdf_pkg::CHAR_SPACE);
         if (has_sign) text.push_back(sign_ch);
         for (int i = nd - 1; i >= 0; i--) text.push_back(digits[i]);
      end
      foreach (text[i]) begin
         fc.ch   = text[i];
         fc.last = (i == text.size() - 1);
         field_chars_q.push_back(fc);
      end
   endfunction

   // random value biased toward digit-count boundaries and extremes
   function automatic logic [VW-1:0] random_value();
      logic [VW-1:0] v;
      logic [VW-1:0] p;
      case ($urandom_range(0, 5))
         0, 1: v = $urandom;
         2: v = $urandom_range(0, 999);
         3: begin
            p = 1;
            repeat ($urandom_range(0, 9)) p = p * 10;
            v = p + $urandom_range(0, 2) - 1;
         end
         4: v = $urandom_range(0, 65535);
         default: begin
            case ($urandom_range(0, 3))
               0: v = 32'h8000_0000;
               1: v = 32'h7FFF_FFFF;
               2: v = 32'h0000_0000;
               default: v = 32'hFFFF_FFFF;
            endcase
         end
      endcase
      if (v != 32'h8000_0000 && $urandom_range(0, 1) == 1) v = 32'd0 - v;
      return v;
   endfunction

   function automatic void queue_req(input logic [VW-1:0] value,
                                     input logic [FW-1:0] flags,
                                     input logic [PWB-1:0] pad_w,
                                     input int idle_pct);
      fmt_req_type r;
      r.value    = value;
      r.flags    = flags;
      r.pad_w    = pad_w;
      r.idle_pct = idle_pct;
      fmt_req_q.push_back(r);
   endfunction

   // driver: present the head request, pop it when the block takes it
   always @(posedge clock) begin : drive_proc
      bit go;
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            format_field(fmt_req_q[0].value, fmt_req_q[0].flags, fmt_req_q[0].pad_w);
            void'(fmt_req_q.pop_front());
         end
         go = 1'b0;
         if (fmt_req_q.size() != 0)
            go = ($urandom_range(0, 99) >= fmt_req_q[0].idle_pct);
         start <= go;
         if (go) begin
            req_value     <= fmt_req_q[0].value;
            req_flags     <= fmt_req_q[0].flags;
            req_pad_width <= fmt_req_q[0].pad_w;
         end
      end
   end

   // monitor: every strobed character against the oldest expectation
   always @(posedge clock) begin : check_proc
      field_char_type want;
      if (!reset && rsp_valid) begin
         if (field_chars_q.size() == 0) begin
            report_mismatch("unexpected character", rsp_ch, 0);
         end else begin
            want = field_chars_q.pop_front();
            if (rsp_ch !== want.ch) report_mismatch("rsp_ch", rsp_ch, want.ch);
            if (rsp_last !== want.last) report_mismatch("rsp_last", rsp_last, want.last);
         end
      end
   end

   // watchdog on cycles with no transaction and no character
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         stall_count <= 0;
      end else if (stall_count >= STALL_LIMIT) begin
         $display("ERROR: no progress for %0d cycles", STALL_LIMIT);
         $display("Simulation FAILED");
         $finish;
      end else begin
         stall_count <= stall_count + 1;
      end
   end

   // stimulus and end of run
   initial begin : stim_proc
      int phase_pct [4];
      error_count = 0;
      stall_count = 0;
      phase_pct = '{0, 63, 0, 38};

      // directed: zero, extremes, sign choice, padding modes, width limits
      queue_req(32'd0,          4'h0, 6'd0,  0);
      queue_req(32'd0,          4'h6, 6'd5,  0);
      queue_req(32'd0,          4'h8, 6'd4,  0);
      queue_req(32'h8000_0000,  4'h0, 6'd0,  0);
      queue_req(32'h8000_0000,  4'h8, 6'd15, 0);
      queue_req(32'h8000_0000,  4'h1, 6'd20, 0);
      queue_req(32'h7FFF_FFFF,  4'h2, 6'd0,  0);
      queue_req(32'h7FFF_FFFF,  4'h4, 6'd12, 0);
      queue_req(32'h7FFF_FFFF,  4'h6, 6'd0,  0);
      queue_req(32'hFFFF_FFFF,  4'h8, 6'd8,  0);
      queue_req(32'd42,         4'hA, 6'd6,  0);
      queue_req(32'd42,         4'h5, 6'd6,  0);
      queue_req(32'd42,         4'h9, 6'd6,  0);
      queue_req(32'd123,        4'h0, 6'd2,  0);
      queue_req(32'd12345,      4'h0, 6'd5,  0);
      queue_req(32'd7,          4'h0, 6'd63, 0);
      queue_req(32'd7,          4'h1, 6'd63, 0);
      queue_req(-32'sd7,        4'h8, 6'd63, 0);
      queue_req(32'd1000000000, 4'hF, 6'd63, 0);
      queue_req(-32'sd99,       4'h6, 6'd10, 0);
      queue_req(32'd999999999,  4'h2, 6'd11, 0);
      queue_req(32'd9,          4'h4, 6'd1,  0);

      // random: mostly short widths, a few long ones
      for (int i = 0; i < 80; i++)
         queue_req(random_value(), 4'($urandom_range(0, 15)),
                   ($urandom_range(0, 9) == 0) ? 6'($urandom_range(0, 63))
                                               : 6'($urandom_range(0, 16)),
                   phase_pct[i / 20]);

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      while (fmt_req_q.size() != 0 || start || field_chars_q.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/core/sdf_pkg.sv
rtl/core/sdf_digit_cell.sv
rtl/core/signed_decimal_field_formatter.sv
sim/tb_signed_decimal_field_formatter.sv
